>>> design/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants of the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int ADDR_BITS    = 16;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int SIZE_W       = ADDR_BITS + 1;
  localparam int ID_W         = 16;
  localparam int ENTRY_W      = 1 + ID_W + SIZE_W + ADDR_BITS;

  localparam logic [SIZE_W-1:0] POOL_MAX = SIZE_W'(1) << ADDR_BITS;
  localparam logic [ID_W-1:0]   ID_LAST  = '1;

  typedef struct packed {
    logic                 used;
    logic [ID_W-1:0]      id;
    logic [SIZE_W-1:0]    size;
    logic [ADDR_BITS-1:0] start;
  } entry_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_WR1, S_WR2, S_DONE
  } state_t;

  localparam logic [2:0] ST_ALLOC    = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FREED    = 3'd3;
  localparam logic [2:0] ST_MERGED   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic REG_FIT  = 1'b0;
  localparam logic REG_POOL = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;

endpackage

>>> design/vpa_ram.sv
// ----------------------------------------------------------------------------
// vpa_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/variable_partition_allocator_unit.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator_unit
// Segment allocator with first, best or worst fit and coalescing on free.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_*      in   tuser: mode; tdata: request_size[16:0], release_id[32:17]
// m_*      out  tdata: status, block_id, start_address, success_count,
//                      failure_count
// cfg_*    in   register write: 0 fit_strategy, 1 pool_size
//
// A request scans the table and decides; when it succeeds it then moves entries,
// makes one or two writes and presents the result, else it goes straight on to
// presenting the result. A new transaction is accepted only after the result
// of the last one has been presented, as all steps share the segment RAM.
// Reset and a pool_size write rebuild entry zero in S_INIT.
// A result waiting on m_tready holds only the final step, not acceptance.
module variable_partition_allocator_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic         s_tuser,   // mode
  input  logic [39:0]  s_tdata,   // request_size, release_id
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // status, block_id, start_address,
                                  // success_count, failure_count
  input  logic         cfg_wen,
  input  logic         cfg_addr,
  input  logic [16:0]  cfg_wdata
);
  import vpa_pkg::*;

  state_t state, state_next;

  logic [1:0]        fit;
  logic [SIZE_W-1:0] pool;
  logic [CNT_W-1:0]  count;
  logic [ID_W-1:0]   next_id;
  logic [31:0]       successes, failures;

  logic              mode_r;
  logic [SIZE_W-1:0] req_r;
  logic [ID_W-1:0]   rid_r;

  logic [CNT_W-1:0]  rd_cnt;
  logic              rvalid;
  logic [IDX_W-1:0]  ridx;
  logic              found, want_next;
  logic [IDX_W-1:0]  pick;
  entry_t            pick_e, prev_e, next_e, last_e;

  logic [IDX_W-1:0]  sh_ra;
  logic [CNT_W-1:0]  sh_left;
  logic              sh_up;
  logic [1:0]        sh_delta;

  logic [IDX_W-1:0]  w1_addr, w2_addr;
  entry_t            w1_e, w2_e;
  logic              wr_two;

  logic [2:0]        res_status;
  logic [ID_W-1:0]   res_id;
  logic [15:0]       res_start;

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  entry_t            wdata, rdata;

  logic              cand, take, match, has_next, mn, mp;
  logic [CNT_W-1:0]  pick_c, down_first;
  logic [SIZE_W-1:0] merged_size;

  vpa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign s_tready = (state == S_IDLE);

  // Scan evaluation of the entry returned by the RAM.
  always_comb begin
    cand  = !rdata.used && (rdata.size >= req_r) && (req_r != '0);
    match = rdata.used && (rdata.id == rid_r);
    case (fit)
      FIT_FIRST: take = cand && !found;
      FIT_BEST:  take = cand && (!found || rdata.size < pick_e.size);
      FIT_WORST: take = cand && (!found || rdata.size >= pick_e.size);
      default:   take = 1'b0;
    endcase
    pick_c      = CNT_W'(pick);
    has_next    = (pick_c + CNT_W'(1)) < count;
    mn          = has_next && !next_e.used;
    mp          = (pick != '0) && !prev_e.used;
    down_first  = pick_c + CNT_W'(1) + CNT_W'(mn);
    merged_size = pick_e.size + (mn ? next_e.size : '0) + (mp ? prev_e.size : '0);
  end

  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = w1_addr;
    wdata = w1_e;
    raddr = rd_cnt[IDX_W-1:0];
    unique case (state)
      S_INIT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = '{used: 1'b0, id: '0, size: pool, start: '0};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_cnt == count && !rvalid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!found || (mode_r == MODE_ALLOC && pick_e.size > req_r
                       && count == CNT_W'(MAX_SEGMENTS))) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        raddr = sh_ra;
        we    = rvalid;
        waddr = sh_up ? ridx + IDX_W'(1) : ridx - IDX_W'(sh_delta);
        wdata = rdata;
        if (sh_left == '0 && !rvalid) begin
          state_next = S_WR1;
        end
      end
      S_WR1: begin
        we         = 1'b1;
        state_next = wr_two ? S_WR2 : S_DONE;
      end
      S_WR2: begin
        we         = 1'b1;
        waddr      = w2_addr;
        wdata      = w2_e;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
    if (cfg_wen && cfg_addr == REG_POOL) begin
      state_next = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit       <= FIT_FIRST;
      pool      <= POOL_MAX;
      count     <= CNT_W'(1);
      next_id   <= ID_W'(1);
      successes <= '0;
      failures  <= '0;
      m_tvalid  <= 1'b0;
      rvalid    <= 1'b0;
    end else begin
      // In S_DONE the result register is reloaded below instead.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wen) begin
        if (cfg_addr == REG_FIT) begin
          fit <= cfg_wdata[1:0];
        end else begin
          pool  <= (cfg_wdata == '0) ? SIZE_W'(1) :
                   (cfg_wdata > POOL_MAX) ? POOL_MAX : cfg_wdata;
          count <= CNT_W'(1);
        end
      end
      case (state)
        S_IDLE: begin
          mode_r    <= s_tuser;
          req_r     <= s_tdata[16:0];
          rid_r     <= s_tdata[32:17];
          rd_cnt    <= '0;
          rvalid    <= 1'b0;
          found     <= 1'b0;
          want_next <= 1'b0;
          pick      <= '0;
        end
        S_SCAN: begin
          rvalid <= (rd_cnt != count);
          ridx   <= rd_cnt[IDX_W-1:0];
          if (rd_cnt != count) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
          if (rvalid) begin
            last_e <= rdata;
            if (want_next) begin
              next_e    <= rdata;
              want_next <= 1'b0;
            end
            if (mode_r == MODE_ALLOC) begin
              if (take) begin
                found  <= 1'b1;
                pick   <= ridx;
                pick_e <= rdata;
              end
            end else if (match && !found) begin
              found     <= 1'b1;
              pick      <= ridx;
              pick_e    <= rdata;
              prev_e    <= last_e;
              want_next <= 1'b1;
            end
          end
        end
        S_DECIDE: begin
          res_id    <= '0;
          res_start <= '0;
          wr_two    <= 1'b0;
          sh_left   <= '0;
          rvalid    <= 1'b0;
          if (mode_r == MODE_ALLOC) begin
            if (!found) begin
              res_status <= ST_NO_FIT;
              failures   <= failures + 32'd1;
            end else if (pick_e.size > req_r && count == CNT_W'(MAX_SEGMENTS)) begin
              res_status <= ST_FULL;
              failures   <= failures + 32'd1;
            end else begin
              res_status <= ST_ALLOC;
              res_id     <= next_id;
              res_start  <= 16'(pick_e.start);
              successes  <= successes + 32'd1;
              next_id    <= (next_id == ID_LAST) ? ID_W'(1) : next_id + ID_W'(1);
              w1_addr    <= pick;
              w1_e       <= '{used: 1'b1, id: next_id, size: req_r, start: pick_e.start};
              w2_addr    <= pick + IDX_W'(1);
              w2_e       <= '{used: 1'b0, id: '0, size: pick_e.size - req_r,
                              start: pick_e.start + ADDR_BITS'(req_r)};
              sh_up      <= 1'b1;
              sh_ra      <= IDX_W'(count - CNT_W'(1));
              if (pick_e.size > req_r) begin
                // Open a hole at pick + 1 by moving the tail up one place.
                wr_two  <= 1'b1;
                sh_left <= count - pick_c - CNT_W'(1);
                count   <= count + CNT_W'(1);
              end
            end
          end else if (!found) begin
            res_status <= ST_NOT_FOUND;
          end else begin
            res_status <= (mn || mp) ? ST_MERGED : ST_FREED;
            res_id     <= rid_r;
            w1_addr    <= mp ? pick - IDX_W'(1) : pick;
            w1_e       <= '{used: 1'b0, id: '0, size: merged_size,
                            start: mp ? prev_e.start : pick_e.start};
            sh_up      <= 1'b0;
            sh_delta   <= {1'b0, mn} + {1'b0, mp};
            sh_ra      <= IDX_W'(down_first);
            sh_left    <= (count > down_first) ? count - down_first : '0;
            count      <= count - CNT_W'({1'b0, mn}) - CNT_W'({1'b0, mp});
          end
        end
        S_SHIFT: begin
          rvalid <= (sh_left != '0);
          ridx   <= sh_ra;
          if (sh_left != '0) begin
            sh_left <= sh_left - CNT_W'(1);
            sh_ra   <= sh_up ? sh_ra - IDX_W'(1) : sh_ra + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, failures, successes, res_start, res_id, res_status};
          end
        end
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !we)
    else $error("table written during scan");

  a_alloc_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == ST_ALLOC |-> m_tdata[18:3] != '0)
    else $error("allocation returned id zero");

endmodule
